>>> rtl/sra_pkg.sv
package sra_pkg;

	localparam int CHANNELS    = 288;
	localparam int SAMPLE_BITS = 12;
	localparam int MAX_PASSES  = 60;

	localparam int FIXED_HIGH_CLOCKS = 3;
	localparam int TAIL_CLOCKS       = 88;

	localparam int CH_W    = $clog2(CHANNELS);
	localparam int IDX_W   = 9;
	localparam int PCNT_W  = 24;
	localparam int PASS_W  = 6;
	localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_PASSES);
	localparam int DCNT_W  = $clog2(SUM_W);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_INTEGRATION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT  = 1'd1;

	localparam logic [PCNT_W-1:0] INTEG_RESET = 24'd9952;
	localparam logic [PASS_W-1:0] PASSES_RESET = 6'd10;

	typedef struct packed {
		logic                   start_req;
		logic                   trigger_level;
		logic [SAMPLE_BITS-1:0] video_sample;
	} item_t;

	typedef struct packed {
		logic                   clock_pulse;
		logic                   start_pulse_level;
		logic                   busy_res;
		logic                   average_valid;
		logic [IDX_W-1:0]       channel_index;
		logic [SAMPLE_BITS-1:0] average_value;
		logic                   last_channel;
	} result_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_STFIX,
		PH_STEXT,
		PH_TAIL,
		PH_CHAN
	} phase_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_FETCH,
		OP_START,
		OP_LEAD,
		OP_STFIX,
		OP_STEXT,
		OP_TAIL,
		OP_CHAN_RD,
		OP_CHAN_ADD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic   trig;
		logic   final_pass;
		phase_t phase;
	} dp_status_t;

endpackage

>>> rtl/sra_divider.sv
module sra_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sra_pkg::op_t                 op,
	input  logic [sra_pkg::SUM_W-1:0]    dividend,
	input  logic [sra_pkg::PASS_W-1:0]   divisor,
	output logic [sra_pkg::SUM_W-1:0]    quotient,
	output logic                         more
);

	logic [sra_pkg::PASS_W-1:0] rem_q;
	logic [sra_pkg::SUM_W-1:0]  quo_q;
	logic [sra_pkg::DCNT_W-1:0] cnt_q;
	logic [sra_pkg::PASS_W:0]   trial;
	logic [sra_pkg::PASS_W:0]   diff;
	logic                       fits;

	// Restoring division, one quotient bit per step, most significant first.
	assign trial = {rem_q, quo_q[sra_pkg::SUM_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (op == sra_pkg::OP_DIV_INIT) begin
			cnt_q <= '0;
		end else if (op == sra_pkg::OP_DIV_STEP) begin
			cnt_q <= cnt_q + sra_pkg::DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (op == sra_pkg::OP_DIV_INIT) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (op == sra_pkg::OP_DIV_STEP) begin
			rem_q <= fits ? diff[sra_pkg::PASS_W-1:0] : trial[sra_pkg::PASS_W-1:0];
			quo_q <= {quo_q[sra_pkg::SUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign more     = cnt_q != sra_pkg::DCNT_W'(sra_pkg::SUM_W - 1);

endmodule

>>> rtl/sra_datapath.sv
module sra_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sra_pkg::op_t                     op,
	input  logic                             item_valid,
	input  sra_pkg::item_t                   item_data,
	input  logic                             cfg_we,
	input  logic [sra_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sra_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [sra_pkg::SUM_W-1:0]        quotient,
	output logic [sra_pkg::SUM_W-1:0]        sum_out,
	output logic [sra_pkg::PASS_W-1:0]       pass_count,
	output sra_pkg::result_t                 res,
	output sra_pkg::dp_status_t              status
);

	sra_pkg::phase_t              phase_q;
	logic [sra_pkg::PCNT_W-1:0]   pcnt_q;
	logic [sra_pkg::CH_W-1:0]     chan_q;
	logic [sra_pkg::PASS_W-1:0]   passes_q;
	logic [sra_pkg::PCNT_W-1:0]   integ_q;
	logic [sra_pkg::PASS_W-1:0]   npass_q;
	sra_pkg::item_t               item_q;
	sra_pkg::result_t             res_q;
	logic [sra_pkg::SUM_W-1:0]    sum_q;
	logic [sra_pkg::SUM_W-1:0]    rd_q;
	logic [sra_pkg::SUM_W-1:0]    sums_q [sra_pkg::CHANNELS];

	logic [sra_pkg::PCNT_W-1:0]   pcnt_inc;
	logic [sra_pkg::CH_W-1:0]     ch_addr;
	logic [sra_pkg::SUM_W-1:0]    sum;
	logic                         final_pass;
	logic                         last_ch;
	logic [sra_pkg::PASS_W-1:0]   cfg_passes;

	localparam logic [sra_pkg::CH_W-1:0] CH_LAST = sra_pkg::CH_W'(sra_pkg::CHANNELS - 1);

	assign pcnt_inc   = pcnt_q + sra_pkg::PCNT_W'(1);
	assign ch_addr    = (chan_q >= CH_LAST) ? CH_LAST : chan_q;
	assign last_ch    = ch_addr == CH_LAST;
	assign final_pass = ({1'b0, passes_q} + (sra_pkg::PASS_W + 1)'(1)) >= {1'b0, npass_q};
	// The first pass writes each entry outright, so no sum is used before it is written.
	assign sum = (passes_q == '0) ? sra_pkg::SUM_W'(item_q.video_sample)
	                              : rd_q + sra_pkg::SUM_W'(item_q.video_sample);

	always_comb begin
		cfg_passes = cfg_data[sra_pkg::PASS_W-1:0];
		if (cfg_passes == '0) begin
			cfg_passes = sra_pkg::PASS_W'(1);
		end else if (cfg_passes > sra_pkg::PASS_W'(sra_pkg::MAX_PASSES)) begin
			cfg_passes = sra_pkg::PASS_W'(sra_pkg::MAX_PASSES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sra_pkg::PH_IDLE;
			pcnt_q   <= '0;
			chan_q   <= '0;
			passes_q <= '0;
			integ_q  <= sra_pkg::INTEG_RESET;
			npass_q  <= sra_pkg::PASSES_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sra_pkg::REG_INTEGRATION: integ_q <= cfg_data[sra_pkg::PCNT_W-1:0];
					sra_pkg::REG_PASS_COUNT:  npass_q <= cfg_passes;
					default: ;
				endcase
			end
			case (op)
				sra_pkg::OP_START: begin
					if (phase_q == sra_pkg::PH_IDLE && item_q.start_req) begin
						passes_q <= '0;
						phase_q  <= sra_pkg::PH_LEAD;
					end
				end
				sra_pkg::OP_LEAD: begin
					pcnt_q  <= '0;
					phase_q <= sra_pkg::PH_STFIX;
				end
				sra_pkg::OP_STFIX: begin
					if (pcnt_inc >= sra_pkg::PCNT_W'(sra_pkg::FIXED_HIGH_CLOCKS)) begin
						pcnt_q  <= '0;
						phase_q <= (integ_q == '0) ? sra_pkg::PH_TAIL : sra_pkg::PH_STEXT;
					end else begin
						pcnt_q <= pcnt_inc;
					end
				end
				sra_pkg::OP_STEXT: begin
					if (pcnt_inc >= integ_q) begin
						pcnt_q  <= '0;
						phase_q <= sra_pkg::PH_TAIL;
					end else begin
						pcnt_q <= pcnt_inc;
					end
				end
				sra_pkg::OP_TAIL: begin
					if (pcnt_inc >= sra_pkg::PCNT_W'(sra_pkg::TAIL_CLOCKS)) begin
						pcnt_q  <= '0;
						chan_q  <= '0;
						phase_q <= sra_pkg::PH_CHAN;
					end else begin
						pcnt_q <= pcnt_inc;
					end
				end
				sra_pkg::OP_CHAN_ADD: begin
					if (last_ch) begin
						chan_q <= '0;
						if (final_pass) begin
							phase_q  <= sra_pkg::PH_IDLE;
							passes_q <= '0;
						end else begin
							passes_q <= passes_q + sra_pkg::PASS_W'(1);
							phase_q  <= sra_pkg::PH_LEAD;
						end
					end else begin
						chan_q <= ch_addr + sra_pkg::CH_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op == sra_pkg::OP_FETCH && item_valid) begin
			item_q <= item_data;
		end
		case (op)
			sra_pkg::OP_START: res_q <= '0;
			sra_pkg::OP_LEAD: begin
				res_q.busy_res    <= 1'b1;
				res_q.clock_pulse <= 1'b1;
			end
			sra_pkg::OP_STFIX, sra_pkg::OP_STEXT: begin
				res_q.busy_res          <= 1'b1;
				res_q.clock_pulse       <= 1'b1;
				res_q.start_pulse_level <= 1'b1;
			end
			sra_pkg::OP_TAIL: begin
				res_q.busy_res    <= 1'b1;
				res_q.clock_pulse <= 1'b1;
			end
			sra_pkg::OP_CHAN_RD: res_q.busy_res <= 1'b1;
			sra_pkg::OP_CHAN_ADD: begin
				res_q.clock_pulse <= 1'b1;
				sum_q             <= sum;
				if (final_pass) begin
					res_q.average_valid <= 1'b1;
					res_q.channel_index <= sra_pkg::IDX_W'(ch_addr);
					res_q.last_channel  <= last_ch;
				end
			end
			sra_pkg::OP_DIV_END: begin
				res_q.average_value <= (quotient > sra_pkg::SUM_W'(sra_pkg::SAMPLE_MAX))
				                       ? sra_pkg::SAMPLE_MAX
				                       : quotient[sra_pkg::SAMPLE_BITS-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == sra_pkg::OP_CHAN_RD) begin
			rd_q <= sums_q[ch_addr];
		end
		if (op == sra_pkg::OP_CHAN_ADD) begin
			sums_q[ch_addr] <= sum;
		end
	end

	assign sum_out           = sum_q;
	assign pass_count        = npass_q;
	assign res               = res_q;
	assign status.trig       = item_q.trigger_level;
	assign status.final_pass = final_pass;
	assign status.phase      = phase_q;

endmodule

>>> rtl/sra_sequencer.sv
module sra_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 out_busy,
	input  logic                 div_more,
	input  sra_pkg::dp_status_t  status,
	output sra_pkg::op_t         op
);

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_NO_TRIG,
		C_NOT_FINAL,
		C_DIV_MORE,
		C_OUT_BUSY,
		C_DISPATCH
	} cond_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		sra_pkg::op_t op;
		cond_t        cond;
		step_t        target;
	} uword_t;

	localparam step_t STEP_EMIT     = 4'd0;
	localparam step_t STEP_FETCH    = 4'd1;
	localparam step_t STEP_START    = 4'd2;
	localparam step_t STEP_DISPATCH = 4'd3;
	localparam step_t STEP_LEAD     = 4'd4;
	localparam step_t STEP_STFIX    = 4'd5;
	localparam step_t STEP_STEXT    = 4'd6;
	localparam step_t STEP_TAIL     = 4'd7;
	localparam step_t STEP_CHAN_RD  = 4'd8;
	localparam step_t STEP_CHAN_ADD = 4'd9;
	localparam step_t STEP_DIV_INIT = 4'd10;
	localparam step_t STEP_DIV_STEP = 4'd11;
	localparam step_t STEP_DIV_END  = 4'd12;

	// Program: a jump is taken when its condition holds, otherwise the next step follows; dispatch jumps by phase.
	function automatic uword_t rom(input step_t s);
		uword_t w;
		case (s)
			STEP_EMIT:     w = '{sra_pkg::OP_EMIT,     C_OUT_BUSY,  STEP_EMIT};
			STEP_FETCH:    w = '{sra_pkg::OP_FETCH,    C_NO_ITEM,   STEP_FETCH};
			STEP_START:    w = '{sra_pkg::OP_START,    C_NEVER,     STEP_FETCH};
			STEP_DISPATCH: w = '{sra_pkg::OP_NONE,     C_DISPATCH,  STEP_EMIT};
			STEP_LEAD:     w = '{sra_pkg::OP_LEAD,     C_ALWAYS,    STEP_EMIT};
			STEP_STFIX:    w = '{sra_pkg::OP_STFIX,    C_ALWAYS,    STEP_EMIT};
			STEP_STEXT:    w = '{sra_pkg::OP_STEXT,    C_ALWAYS,    STEP_EMIT};
			STEP_TAIL:     w = '{sra_pkg::OP_TAIL,     C_ALWAYS,    STEP_EMIT};
			STEP_CHAN_RD:  w = '{sra_pkg::OP_CHAN_RD,  C_NO_TRIG,   STEP_EMIT};
			STEP_CHAN_ADD: w = '{sra_pkg::OP_CHAN_ADD, C_NOT_FINAL, STEP_EMIT};
			STEP_DIV_INIT: w = '{sra_pkg::OP_DIV_INIT, C_NEVER,     STEP_FETCH};
			STEP_DIV_STEP: w = '{sra_pkg::OP_DIV_STEP, C_DIV_MORE,  STEP_DIV_STEP};
			STEP_DIV_END:  w = '{sra_pkg::OP_DIV_END,  C_ALWAYS,    STEP_EMIT};
			default:       w = '{sra_pkg::OP_NONE,     C_ALWAYS,    STEP_FETCH};
		endcase
		return w;
	endfunction

	function automatic step_t dispatch(input sra_pkg::phase_t p);
		step_t s;
		case (p)
			sra_pkg::PH_LEAD:  s = STEP_LEAD;
			sra_pkg::PH_STFIX: s = STEP_STFIX;
			sra_pkg::PH_STEXT: s = STEP_STEXT;
			sra_pkg::PH_TAIL:  s = STEP_TAIL;
			sra_pkg::PH_CHAN:  s = STEP_CHAN_RD;
			default:           s = STEP_EMIT;
		endcase
		return s;
	endfunction

	step_t  pc_q;
	step_t  pc_d;
	uword_t word;
	logic   take;

	assign word = rom(pc_q);

	always_comb begin
		case (word.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_ITEM:   take = !item_valid;
			C_NO_TRIG:   take = !status.trig;
			C_NOT_FINAL: take = !status.final_pass;
			C_DIV_MORE:  take = div_more;
			C_OUT_BUSY:  take = out_busy;
			default:     take = 1'b0;
		endcase
		if (word.cond == C_DISPATCH) begin
			pc_d = dispatch(status.phase);
		end else if (take) begin
			pc_d = word.target;
		end else begin
			pc_d = pc_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign op = word.op;

endmodule

>>> rtl/spectrometer_readout_averager.sv
// Readout sequencer with frame averaging for a linear image sensor. Each input transfer is
// one sensor clock tick and gives exactly one result transfer: whether to drive a clock, the
// start-pulse level, busy, and in the last pass each channel's average (sum over passes
// divided by the pass count, truncated and saturated) with a flag on the final channel.
// Configuration (index 0: extra integration clocks, index 1: pass count, low six bits
// saturated to 1..60) is to be written by the user only while no tick is in progress; the
// block itself does not enforce this. One tick at a time goes through a microcoded
// sequencer: fetch, start, dispatch, then a phase step for a lead, start-pulse or tail tick,
// or for a sample a read of the channel sum from the 288-entry memory, which with the
// trigger low is a sampling wait and otherwise is accumulated and, in the last pass, divided
// by the restoring divider at one quotient bit per cycle, and last the emit. A new tick is
// taken as soon as the previous result has entered the output register, even while it waits
// to be taken; a result that cannot enter that register holds the sequencer. Channel sums
// need no clearing after reset, because the first pass writes every entry.
module spectrometer_readout_averager (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  sra_pkg::item_t                   item_data,
	output logic                             result_valid,
	input  logic                             result_stall,
	output sra_pkg::result_t                 result_data,
	input  logic                             cfg_we,
	input  logic [sra_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sra_pkg::CFG_DATA_W-1:0]   cfg_data
);

	sra_pkg::op_t                op;
	sra_pkg::dp_status_t         status;
	sra_pkg::result_t            res;
	logic [sra_pkg::SUM_W-1:0]   sum;
	logic [sra_pkg::SUM_W-1:0]   quotient;
	logic [sra_pkg::PASS_W-1:0]  pass_count;
	logic                        div_more;
	logic                        out_busy;
	logic                        load;
	logic                        result_valid_q;
	sra_pkg::result_t            result_q;

	assign out_busy   = result_valid_q && result_stall;
	assign load       = (op == sra_pkg::OP_EMIT) && !out_busy;
	assign item_stall = op != sra_pkg::OP_FETCH;

	sra_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.out_busy   (out_busy),
		.div_more   (div_more),
		.status     (status),
		.op         (op)
	);

	sra_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.item_valid (item_valid),
		.item_data  (item_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.quotient   (quotient),
		.sum_out    (sum),
		.pass_count (pass_count),
		.res        (res),
		.status     (status)
	);

	sra_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.dividend (sum),
		.divisor  (pass_count),
		.quotient (quotient),
		.more     (div_more)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

`ifndef SYNTHESIS
	// Once a tick is taken the sequencer must leave the fetch step.
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input not stalled after a transfer");

	// A finished result enters the output register as soon as there is room.
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(op == sra_pkg::OP_EMIT && !out_busy) |=> result_valid)
		else $error("result not loaded at emit");

	// An average only comes with a sampling clock in a running measurement.
	a_average_context: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.average_valid) |->
		(result_data.busy_res && result_data.clock_pulse && !result_data.start_pulse_level))
		else $error("average outside a sampling tick");
`endif

endmodule
